// ===== sv/winder_motor_run_controller_unit_macros.svh =====
// Assertion macros shared by the winder motor run controller RTL.
`ifndef WINDER_MOTOR_RUN_CONTROLLER_UNIT_MACROS_SVH
`define WINDER_MOTOR_RUN_CONTROLLER_UNIT_MACROS_SVH

// ante implies cons in the same cycle
`define WMRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define WMRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/wmrc_pkg.sv =====
// Types, codes and constants of the winder motor run controller.
package wmrc_pkg;

   localparam int SPEED_LIMIT = 4095;
   localparam int TEST_SPEED  = 100;

   localparam int CMD_W      = 3;
   localparam int MODE_W     = 3;
   localparam int SPEED_W    = 12;
   localparam int SPINS_W    = 16;
   localparam int PAPER_W    = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SPEED_W-1:0] SPEED_CAP =
      SPEED_W'((SPEED_LIMIT > 4095) ? 4095 : SPEED_LIMIT);
   localparam logic [SPEED_W-1:0] TEST_DUTY = SPEED_W'(TEST_SPEED & 4095);
   localparam logic [SPEED_W-1:0] MAX_VELOCITY_RESET = SPEED_W'(4095);

   // braking window: min(floor(3 * target / 10), 30)
   localparam int BRAKE_WINDOW_MAX = 30;
   localparam int BRAKE_FULL_FROM  = 104;
   localparam int BRAKE_RECIP      = 205;
   localparam int BRAKE_SHIFT      = 11;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF    = 3'd0,
      MODE_RUN    = 3'd1,
      MODE_BRAKE  = 3'd2,
      MODE_PAUSE  = 3'd3,
      MODE_HALT   = 3'd4,
      MODE_FINISH = 3'd5,
      MODE_TEST   = 3'd6
   } mode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE   = 3'd0,
      CMD_TOGGLE = 3'd1,
      CMD_HALT   = 3'd2,
      CMD_UP     = 3'd3,
      CMD_DOWN   = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [PAPER_W-1:0] {
      PAPER_UNKNOWN = 2'd0,
      PAPER_PRESENT = 2'd1,
      PAPER_CUT     = 2'd2
   } paper_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_SPINS    = 1'b0,
      REG_MAX_VELOCITY = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [SPINS_W-1:0] max_spins;
      logic [SPEED_W-1:0] max_velocity;
      logic [SPINS_W-1:0] brake_point;
   } cfg_type;

   typedef struct packed {
      cmd_type cmd;
      logic    spin_level;
      logic    paper_up_level;
      logic    paper_down_level;
      logic    test_level;
   } item_type;

   typedef struct packed {
      mode_type           mode;
      logic [SPEED_W-1:0] speed;
      logic [SPINS_W-1:0] spins;
      logic               last_spin;
      paper_type          upper;
      paper_type          lower;
      logic               enable;
      logic               valve;
   } state_type;

   typedef struct packed {
      mode_type           run_state;
      logic [SPEED_W-1:0] pwm_duty;
      logic               motor_enable;
      logic               valve_on;
      logic [SPINS_W-1:0] spin_total;
      paper_type          upper_paper;
      paper_type          lower_paper;
      logic               done_pulse;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode:      MODE_OFF,
      speed:     '0,
      spins:     '0,
      last_spin: 1'b0,
      upper:     PAPER_UNKNOWN,
      lower:     PAPER_UNKNOWN,
      enable:    1'b0,
      valve:     1'b0
   };

endpackage

// ===== sv/wmrc_ifs.sv =====
// Request and response channel interfaces of the winder motor run controller.
interface wmrc_req_if;
   logic                            valid;
   logic                            ready;
   logic [wmrc_pkg::CMD_W-1:0]      cmd;
   logic                            spin_level;
   logic                            paper_up_level;
   logic                            paper_down_level;
   logic                            test_level;

   modport source (output valid, cmd, spin_level, paper_up_level, paper_down_level,
                   test_level, input ready);
   modport sink (input valid, cmd, spin_level, paper_up_level, paper_down_level,
                 test_level, output ready);
endinterface

interface wmrc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wmrc_pkg::MODE_W-1:0]     run_state;
   logic [wmrc_pkg::SPEED_W-1:0]    pwm_duty;
   logic                            motor_enable;
   logic                            valve_on;
   logic [wmrc_pkg::SPINS_W-1:0]    spin_total;
   logic [wmrc_pkg::PAPER_W-1:0]    upper_paper;
   logic [wmrc_pkg::PAPER_W-1:0]    lower_paper;
   logic                            done_pulse;

   modport source (output valid, run_state, pwm_duty, motor_enable, valve_on, spin_total,
                   upper_paper, lower_paper, done_pulse, input ready);
   modport sink (input valid, run_state, pwm_duty, motor_enable, valve_on, spin_total,
                 upper_paper, lower_paper, done_pulse, output ready);
endinterface

// ===== sv/wmrc_csr.sv =====
// Configuration registers and the derived braking point.
module wmrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wmrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wmrc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output wmrc_pkg::cfg_type                   cfg
);

   logic [wmrc_pkg::SPINS_W-1:0] max_spins_ff;
   logic [wmrc_pkg::SPEED_W-1:0] max_velocity_ff;
   logic [8:0]                   triple;
   logic [15:0]                  scaled;
   logic [4:0]                   window;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_spins_ff    <= '0;
         max_velocity_ff <= wmrc_pkg::MAX_VELOCITY_RESET;
      end else if (csr_we) begin
         case (wmrc_pkg::csr_reg_type'(csr_index))
            wmrc_pkg::REG_MAX_SPINS: begin
               max_spins_ff <= csr_wdata[wmrc_pkg::SPINS_W-1:0];
            end
            wmrc_pkg::REG_MAX_VELOCITY: begin
               max_velocity_ff <= csr_wdata[wmrc_pkg::SPEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // floor(3x/10) as (3x * 205) >> 11, exact for 3x below 1029
   assign triple = {1'b0, max_spins_ff[6:0], 1'b0} + {2'b00, max_spins_ff[6:0]};
   assign scaled = 16'(triple) * 16'(wmrc_pkg::BRAKE_RECIP);

   always_comb begin
      if (max_spins_ff >= wmrc_pkg::SPINS_W'(wmrc_pkg::BRAKE_FULL_FROM)) begin
         window = 5'(wmrc_pkg::BRAKE_WINDOW_MAX);
      end else begin
         window = scaled[wmrc_pkg::BRAKE_SHIFT+4:wmrc_pkg::BRAKE_SHIFT];
      end
   end

   assign cfg.max_spins    = max_spins_ff;
   assign cfg.max_velocity = max_velocity_ff;
   assign cfg.brake_point  = max_spins_ff - wmrc_pkg::SPINS_W'(window);

endmodule

// ===== sv/wmrc_step.sv =====
// One control tick: next controller state and the result word.
module wmrc_step (
   input  wmrc_pkg::state_type   cur,
   input  wmrc_pkg::cfg_type     cfg,
   input  wmrc_pkg::item_type    item,
   output wmrc_pkg::state_type   nxt,
   output wmrc_pkg::result_type  res
);

   logic done;
   logic active;

   always_comb begin
      nxt  = cur;
      done = 1'b0;

      case (item.cmd)
         wmrc_pkg::CMD_TOGGLE: begin
            if (cur.mode == wmrc_pkg::MODE_RUN || cur.mode == wmrc_pkg::MODE_BRAKE) begin
               nxt.mode = wmrc_pkg::MODE_PAUSE;
            end else begin
               nxt.mode = wmrc_pkg::MODE_RUN;
            end
            nxt.speed = '0;
         end
         wmrc_pkg::CMD_HALT: begin
            nxt.mode  = wmrc_pkg::MODE_HALT;
            nxt.speed = '0;
         end
         wmrc_pkg::CMD_UP: begin
            if (cur.speed >= cfg.max_velocity) begin
               nxt.speed = cfg.max_velocity;
            end else begin
               nxt.speed = cur.speed + 1'b1;
            end
         end
         wmrc_pkg::CMD_DOWN: begin
            if (cur.speed != '0) begin
               nxt.speed = cur.speed - 1'b1;
            end
         end
         wmrc_pkg::CMD_CLEAR: begin
            nxt.spins = '0;
         end
         default: begin
         end
      endcase

      if (nxt.speed > wmrc_pkg::SPEED_CAP) begin
         nxt.speed = wmrc_pkg::SPEED_CAP;
      end

      // test button is active low
      if (!item.test_level && nxt.mode != wmrc_pkg::MODE_TEST) begin
         nxt.mode   = wmrc_pkg::MODE_TEST;
         nxt.speed  = wmrc_pkg::TEST_DUTY;
         nxt.enable = 1'b1;
      end
      if (item.test_level && nxt.mode == wmrc_pkg::MODE_TEST) begin
         nxt.mode   = wmrc_pkg::MODE_OFF;
         nxt.speed  = '0;
         nxt.enable = 1'b0;
      end

      if (nxt.mode == wmrc_pkg::MODE_RUN) begin
         nxt.enable = 1'b1;
         nxt.valve  = 1'b0;
      end
      if (nxt.mode == wmrc_pkg::MODE_PAUSE || nxt.mode == wmrc_pkg::MODE_HALT) begin
         nxt.enable = 1'b0;
         nxt.valve  = 1'b1;
      end

      if (item.spin_level && !cur.last_spin && nxt.spins < cfg.max_spins) begin
         nxt.spins = nxt.spins + 1'b1;
      end
      nxt.last_spin = item.spin_level;

      nxt.upper = item.paper_up_level ? wmrc_pkg::PAPER_CUT : wmrc_pkg::PAPER_PRESENT;
      nxt.lower = item.paper_down_level ? wmrc_pkg::PAPER_CUT : wmrc_pkg::PAPER_PRESENT;

      active = nxt.mode == wmrc_pkg::MODE_RUN || nxt.mode == wmrc_pkg::MODE_BRAKE;
      if ((item.paper_up_level || item.paper_down_level) && active) begin
         nxt.enable = 1'b0;
         nxt.mode   = wmrc_pkg::MODE_HALT;
         nxt.speed  = '0;
      end

      if (nxt.mode == wmrc_pkg::MODE_RUN || nxt.mode == wmrc_pkg::MODE_BRAKE) begin
         if (nxt.mode == wmrc_pkg::MODE_RUN && nxt.spins > cfg.brake_point) begin
            nxt.mode = wmrc_pkg::MODE_BRAKE;
         end
         if (nxt.spins >= cfg.max_spins) begin
            nxt.enable = 1'b0;
            nxt.speed  = '0;
            nxt.mode   = wmrc_pkg::MODE_FINISH;
            done       = 1'b1;
         end
      end
   end

   assign res.run_state    = nxt.mode;
   assign res.pwm_duty     = nxt.speed;
   assign res.motor_enable = nxt.enable;
   assign res.valve_on     = nxt.valve;
   assign res.spin_total   = nxt.spins;
   assign res.upper_paper  = nxt.upper;
   assign res.lower_paper  = nxt.lower;
   assign res.done_pulse   = done;

endmodule

// ===== sv/winder_motor_run_controller_unit.sv =====
// Top level of the winder motor run controller: input stage, state and result register.
//
// One request word is one control tick (command plus sensor levels) and yields exactly
// one response word with the run state, drive duty, enables, spin count and paper status
// as they stand after that tick. Throughput is one word per clock while responses are
// taken. A request lands in the input register when it is accepted; it then passes
// through the tick logic into the result register, which also updates the controller
// state, once the response register is empty or being read. A full response register
// does not block intake: one further request is held in the input register.
// Configuration writes (target spins, speed ceiling) take effect on the next tick and
// must be issued while no word is in flight.
`include "winder_motor_run_controller_unit_macros.svh"

module winder_motor_run_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   wmrc_req_if.sink                            req_ch,
   wmrc_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [wmrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wmrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   wmrc_pkg::cfg_type     cfg;
   wmrc_pkg::item_type    item_in;
   wmrc_pkg::item_type    item_ff;
   wmrc_pkg::state_type   state_ff;
   wmrc_pkg::state_type   state_in;
   wmrc_pkg::result_type  result_in;
   wmrc_pkg::result_type  result_ff;
   logic                  item_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;

   wmrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wmrc_step u_step (
      .cur  (state_ff),
      .cfg  (cfg),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;

   assign item_in.cmd              = wmrc_pkg::cmd_type'(req_ch.cmd);
   assign item_in.spin_level       = req_ch.spin_level;
   assign item_in.paper_up_level   = req_ch.paper_up_level;
   assign item_in.paper_down_level = req_ch.paper_down_level;
   assign item_in.test_level       = req_ch.test_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= wmrc_pkg::STATE_RESET;
      end else begin
         if (req_ch.ready) begin
            item_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.run_state    = result_ff.run_state;
   assign rsp_ch.pwm_duty     = result_ff.pwm_duty;
   assign rsp_ch.motor_enable = result_ff.motor_enable;
   assign rsp_ch.valve_on     = result_ff.valve_on;
   assign rsp_ch.spin_total   = result_ff.spin_total;
   assign rsp_ch.upper_paper  = result_ff.upper_paper;
   assign rsp_ch.lower_paper  = result_ff.lower_paper;
   assign rsp_ch.done_pulse   = result_ff.done_pulse;

   `WMRC_ASSERT_NOW(a_done_is_finish, clock, reset,
      rsp_valid_ff && result_ff.done_pulse,
      result_ff.run_state == wmrc_pkg::MODE_FINISH, "done word without finished state")
   `WMRC_ASSERT_NEXT(a_advance_fills_rsp, clock, reset,
      advance, rsp_valid_ff, "advanced word did not reach response register")
   `WMRC_ASSERT_NOW(a_stall_has_item, clock, reset,
      !req_ch.ready, item_valid_ff && rsp_valid_ff, "intake stalled without a full pipeline")
   `WMRC_ASSERT_NOW(a_run_drives_motor, clock, reset,
      state_ff.mode == wmrc_pkg::MODE_RUN || state_ff.mode == wmrc_pkg::MODE_TEST,
      state_ff.enable, "running or test without motor enable")

endmodule
